@@ hdl/sha384_pkg.sv @@
// SHA-384 package: round constants, initial hash values, action codes and helpers.
// No dependencies; used by the core.
package sha384_pkg;

  localparam int unsigned BlockBytes = 128;
  localparam int unsigned LenFieldAt = 112;
  localparam int unsigned DigestWords = 6;
  localparam int unsigned Rounds = 80;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic ActAbsorb = 1'b0;
  localparam logic ActFinish = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [7:0][63:0] Iv384 = {
    64'h47b5481dbefa4fa4, 64'hdb0c2e0d64f98fa7, 64'h8eb44a8768581511, 64'h67332667ffc00b31,
    64'h152fecd8f70e5939, 64'h9159015a3070dd17, 64'h629a292a367cd507, 64'hcbbb9d5dc1059ed8
  };

  function automatic logic [63:0] round_k(input logic [6:0] t);
    logic [63:0] k;
    unique case (t)
      7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

@@ hdl/sha384_stream_if.sv @@
// Valid/ready channel carrying one packed payload.
// Generic in its payload type; has no dependencies.
interface sha384_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/sha384_stream_hasher_core.sv @@
// SHA-384 stream hasher core: message schedule filled byte by byte and one shared round unit.
// Depends on sha384_pkg and sha384_stream_if.
//
//  channel  dir  payload                               transaction
//  in_if    in   action, data_byte                     one byte absorbed or a finish
//  out_if   out  digest_word, word_index, last_word    one digest word
//
// An absorb writes one byte; when it fills the block a compression follows: bytes land
// straight in the schedule registers, StLoad loads the working words, then the round
// unit runs one round a cycle and StAdd adds into the chain. A finish writes padding
// one byte a cycle (at most 144 bytes, two compressions when the 0x80 marker lands at
// offset 112 or later), then emits six words; the result register holds while out ready
// is low and the input stays not ready until the last word goes. Reset loads the initial
// hash values and clears counters and the block registers.
module sha384_stream_hasher_core
  import sha384_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  sha384_stream_if.sink      in_if,
  sha384_stream_if.source    out_if
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StLoad  = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [7:0][63:0]  chain_q;
  logic [7:0][63:0]  v_q;
  logic [15:0][63:0] w_q;
  logic [6:0]        fill_q;
  logic [63:0]       bits_q;
  logic [63:0]       len_q;
  logic [6:0]        cnt_q;
  logic              fin_q;
  logic [2:0]        idx_q;
  logic              ovalid_q;
  logic [63:0]       oword_q;
  // length field lands in the block being filled; marks the final compression of a finish
  logic              fill_done_q;

  // padding byte for the current fill position
  logic [7:0]  pad_byte;
  logic [2:0]  lsel;
  assign lsel = fill_q[2:0];
  always_comb begin
    if (!fin_q) begin
      pad_byte = PadByte;
    end else if (fill_done_q && fill_q >= 7'(LenFieldAt + 8)) begin
      pad_byte = len_q[8'(7 - lsel) * 8 +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  logic       wr_en;
  logic [7:0] wr_byte;
  logic       acc;
  assign in_if.ready = (state_q == StIdle);
  assign acc = in_if.valid && in_if.ready;
  always_comb begin
    wr_en   = 1'b0;
    wr_byte = in_if.payload.data_byte;
    if (acc && in_if.payload.action == ActAbsorb) begin
      wr_en = 1'b1;
    end else if (state_q == StPad) begin
      wr_en   = 1'b1;
      wr_byte = pad_byte;
    end
  end

  // shared round unit
  logic [63:0] s0, s1, wnew, big0, big1, ch, maj, t1, t2, wt;
  assign s0   = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
  assign s1   = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
  assign wnew = w_q[0] + s0 + w_q[9] + s1;
  assign wt   = w_q[0];
  assign big1 = rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41);
  assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + round_k(cnt_q) + wt;
  assign big0 = rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39);
  assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + maj;

  logic full_now;
  assign full_now = (fill_q == 7'(BlockBytes - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          if (in_if.payload.action == ActFinish) state_d = StPad;
          else if (full_now) state_d = StLoad;
        end
      end
      StPad: begin
        if (full_now) state_d = StLoad;
      end
      StLoad:  state_d = StRound;
      StRound: if (cnt_q == 7'(Rounds - 1)) state_d = StAdd;
      StAdd: begin
        if (!fin_q) state_d = StIdle;
        else if (fill_done_q) state_d = StEmit;
        else state_d = StPad;
      end
      StEmit: if (out_if.ready && ovalid_q && idx_q == 3'(DigestWords - 1)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      chain_q     <= Iv384;
      v_q         <= '0;
      w_q         <= '0;
      fill_q      <= '0;
      bits_q      <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      idx_q       <= '0;
      ovalid_q    <= 1'b0;
      oword_q     <= '0;
      fill_done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // bytes go straight into the schedule words, most significant byte first
      if (wr_en) begin
        fill_q <= fill_q + 7'd1;
        w_q[fill_q[6:3]][{~fill_q[2:0], 3'b000} +: 8] <= wr_byte;
      end
      unique case (state_q)
        StIdle: begin
          cnt_q <= '0;
          if (acc) begin
            if (in_if.payload.action == ActAbsorb) begin
              bits_q <= bits_q + 64'd8;
            end else begin
              len_q <= bits_q;
              fin_q <= 1'b0;
              fill_done_q <= 1'b0;
            end
          end
        end
        StPad: begin
          fin_q <= 1'b1;
          // a 0x80 at offset 112 or later pushes the length into a second block
          if (!fin_q) fill_done_q <= (fill_q < 7'(LenFieldAt));
          cnt_q <= '0;
        end
        StLoad: begin
          v_q   <= chain_q;
          cnt_q <= '0;
        end
        StRound: begin
          cnt_q <= cnt_q + 7'd1;
          w_q   <= {wnew, w_q[15:1]};
          v_q   <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
        end
        StAdd: begin
          for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
          fill_q <= '0;
          if (fin_q) begin
            if (fill_done_q) begin
              idx_q    <= '0;
              ovalid_q <= 1'b1;
              oword_q  <= chain_q[0] + v_q[0];
            end else begin
              fill_done_q <= 1'b1;
            end
          end
        end
        StEmit: begin
          if (out_if.ready && ovalid_q) begin
            if (idx_q == 3'(DigestWords - 1)) begin
              ovalid_q <= 1'b0;
              chain_q  <= Iv384;
              bits_q   <= '0;
              fin_q    <= 1'b0;
              fill_q   <= '0;
            end else begin
              idx_q   <= idx_q + 3'd1;
              oword_q <= chain_q[idx_q + 3'd1];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_if.valid               = ovalid_q;
  assign out_if.payload.digest_word = oword_q;
  assign out_if.payload.word_index  = idx_q;
  assign out_if.payload.last_word   = (idx_q == 3'(DigestWords - 1));

  assert property (@(posedge clk_i) disable iff (!rst_ni) ovalid_q |-> state_q == StEmit)
    else $error("digest valid outside emit");
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_if.ready |-> !ovalid_q)
    else $error("input ready while digest pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound |-> cnt_q < 7'(Rounds))
    else $error("round counter overrun");

endmodule
